// ----- sv/nsqrt_pkg.sv -----
// Shared constants and types for the Newton-Raphson square root block.
// Holds fixed-point format, field widths, register indexes and status codes.
// No dependencies.
`timescale 1ns / 1ps

package nsqrt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;

    localparam int RAD_W    = 32;
    localparam int ROOT_W   = 32;
    localparam int STATUS_W = 2;
    localparam int STEPS_W  = 6;
    localparam int TOL_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int GUESS_W  = DATA_WIDTH;
    localparam int TARGET_W = DATA_WIDTH - 1 + FRAC_BITS;
    localparam int SQ_W     = 2 * DATA_WIDTH;
    localparam int DIFF_W   = SQ_W + 1;
    localparam int DIV_CNT_W = $clog2(TARGET_W + 1);

    localparam int OUT_W = ROOT_W + STATUS_W + STEPS_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [TOL_W-1:0]   TOL_RESET      = TOL_W'(429497);
    localparam logic [STEPS_W-1:0] MAX_ITER_RESET = STEPS_W'(32);

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INPUT = 2'd1,
        ST_CAP       = 2'd2
    } status_t;

    typedef struct packed {
        logic [STEPS_W-1:0] steps_taken;
        status_t            status;
        logic [ROOT_W-1:0]  root;
    } result_t;

endpackage

// ----- sv/newton_square_root_top.sv -----
// Newton-Raphson square root of a signed Q16.16 radicand, streaming in and out.
// Each step squares the guess, takes the difference and tests it; if it fails and the step cap
// is not reached, a restoring divider runs and the guess is updated. A rejected radicand goes straight to the result.
// Throughput: one radicand at a time; next input taken once the result is staged.
// Reset: asynchronous active low; tolerance 429497, max_iterations 32.
// Depends on nsqrt_pkg.
`timescale 1ns / 1ps

module newton_square_root_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [nsqrt_pkg::RAD_W-1:0]      s_tdata,   // [31:0] radicand
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [nsqrt_pkg::OUT_BYTES_W-1:0] m_tdata,  // [31:0] root, [33:32] status,
                                                        // [39:34] steps_taken
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nsqrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nsqrt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int GW = nsqrt_pkg::GUESS_W;
    localparam int TW = nsqrt_pkg::TARGET_W;
    localparam int FB = nsqrt_pkg::FRAC_BITS;
    localparam logic [GW-1:0] GUESS_ONE = GW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_DIFF,
        S_TEST,
        S_DIV,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [nsqrt_pkg::TOL_W-1:0]   tol_reg;
    logic [nsqrt_pkg::STEPS_W-1:0] max_iter_reg;

    logic [GW-1:0]                       guess_reg;
    logic [TW-1:0]                       target_reg;
    logic [nsqrt_pkg::SQ_W-1:0]          sq_reg;
    logic [nsqrt_pkg::DIFF_W-1:0]        diff_reg;
    logic [nsqrt_pkg::STEPS_W-1:0]       steps_reg;
    nsqrt_pkg::status_t                  status_reg;
    logic [TW-1:0]                       quo_reg;
    logic [GW-1:0]                       rem_reg;
    logic [nsqrt_pkg::DIV_CNT_W-1:0]     div_cnt_reg;
    logic                                out_valid_reg;
    nsqrt_pkg::result_t                  out_reg;

    logic [GW-1:0]                 raw;
    logic                          bad_input;
    logic [GW-1:0]                 guess_init;
    logic [nsqrt_pkg::SQ_W-1:0]    sq_next;
    logic [nsqrt_pkg::DIFF_W-1:0]  diff_next;
    logic [nsqrt_pkg::DIFF_W-1:0]  neg_sum;
    logic                          test_fail;
    logic [GW:0]                   rem_shift;
    logic                          rem_ge;
    logic [GW-1:0]                 rem_next;
    logic [TW-1:0]                 quo_next;
    logic [TW:0]                   upd_sum;
    logic [TW-1:0]                 upd_half;
    logic [GW-1:0]                 guess_next;
    logic                          out_free;

    assign raw        = s_tdata[GW-1:0];
    assign bad_input  = (raw == '0) || raw[GW-1];
    assign guess_init = (raw[GW-1:1] == '0) ? GUESS_ONE : {1'b0, raw[GW-1:1]};

    assign sq_next   = guess_reg * guess_reg;
    assign diff_next = {1'b0, sq_reg} - nsqrt_pkg::DIFF_W'(target_reg);
    assign neg_sum   = diff_reg + nsqrt_pkg::DIFF_W'(tol_reg);
    assign test_fail = diff_reg[nsqrt_pkg::DIFF_W-1] ? neg_sum[nsqrt_pkg::DIFF_W-1]
                     : (diff_reg[nsqrt_pkg::SQ_W-1:0] > nsqrt_pkg::SQ_W'(tol_reg));

    assign rem_shift = {rem_reg, quo_reg[TW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, guess_reg});
    assign rem_next  = rem_ge ? GW'(rem_shift - {1'b0, guess_reg}) : rem_shift[GW-1:0];
    assign quo_next  = {quo_reg[TW-2:0], rem_ge};

    assign upd_sum  = (TW + 1)'(guess_reg) + {1'b0, quo_reg};
    assign upd_half = upd_sum[TW:1];
    always_comb
    begin
        if (|upd_half[TW-1:GW])
        begin
            guess_next = '1;
        end
        else if (upd_half[GW-1:0] == '0)
        begin
            guess_next = GUESS_ONE;
        end
        else
        begin
            guess_next = upd_half[GW-1:0];
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = nsqrt_pkg::OUT_BYTES_W'(out_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= nsqrt_pkg::TOL_RESET;
            max_iter_reg <= nsqrt_pkg::MAX_ITER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                nsqrt_pkg::REG_TOLERANCE: tol_reg <= cfg_data[nsqrt_pkg::TOL_W-1:0];
                nsqrt_pkg::REG_MAX_ITER:  max_iter_reg <= cfg_data[nsqrt_pkg::STEPS_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Sequencer and shared divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            guess_reg     <= '0;
            target_reg    <= '0;
            sq_reg        <= '0;
            diff_reg      <= '0;
            steps_reg     <= '0;
            status_reg    <= nsqrt_pkg::ST_OK;
            quo_reg       <= '0;
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        steps_reg  <= '0;
                        target_reg <= {raw[GW-2:0], {FB{1'b0}}};
                        if (bad_input)
                        begin
                            guess_reg  <= '0;
                            status_reg <= nsqrt_pkg::ST_BAD_INPUT;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            guess_reg  <= guess_init;
                            status_reg <= nsqrt_pkg::ST_OK;
                            state_reg  <= S_SQUARE;
                        end
                    end
                end
                S_SQUARE:
                begin
                    sq_reg    <= sq_next;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    diff_reg  <= diff_next;
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (!test_fail)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (steps_reg >= max_iter_reg)
                    begin
                        status_reg <= nsqrt_pkg::ST_CAP;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        quo_reg     <= target_reg;
                        rem_reg     <= '0;
                        div_cnt_reg <= nsqrt_pkg::DIV_CNT_W'(TW - 1);
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    quo_reg     <= quo_next;
                    rem_reg     <= rem_next;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    guess_reg <= guess_next;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_SQUARE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg.root        <= guess_reg;
                        out_reg.status      <= status_reg;
                        out_reg.steps_taken <= steps_reg;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (guess_reg != '0))
        else $error("divider started with zero divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_SQUARE || state_reg == S_DONE))
        else $error("accepted beat did not start a root");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not staged");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == nsqrt_pkg::ST_BAD_INPUT)
            |-> (out_reg.root == '0 && out_reg.steps_taken == '0))
        else $error("rejected radicand with nonzero root or steps");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> (steps_reg != '1))
        else $error("step count wrapped");

endmodule
